// File: rtl/icf_pkg.sv
`default_nettype none
package icf_pkg;
  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_MUL    = 3'd2,
    OP_DIV    = 3'd3,
    OP_ASSIGN = 3'd4,
    OP_RETURN = 3'd5
  } op_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic        left_is_const;
    logic [63:0] left_operand;
    logic        right_is_const;
    logic [63:0] right_operand;
    logic [63:0] dest_temp;
    logic        function_start;
  } instr_t;

  typedef struct packed {
    logic [2:0]  out_mode;
    logic        out_left_is_const;
    logic [63:0] out_left_operand;
    logic        out_right_is_const;
    logic [63:0] out_right_operand;
    logic [63:0] out_dest_temp;
  } result_t;
endpackage
`default_nettype wire

// File: rtl/icf_if.sv
`default_nettype none
interface icf_in_if;
  logic             valid;
  logic             ready;
  icf_pkg::instr_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface icf_out_if;
  logic             valid;
  logic             ready;
  icf_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/ir_constant_folder_top.sv
// A transaction runs S_RDL, S_RDR, S_EXEC, then S_OUT sets result valid for assign, return,
// add, sub, unfolded ops; a folded mul adds four 64x16 steps, a folded div a bit-serial loop.
// One instruction in flight, the next taken in S_IDLE once the last result is registered;
// a result not yet taken holds the instruction behind it before execute.
// Reset clears control, fold_enable and epoch, then a pass in S_CLR clears every tag;
// the same pass runs before the function start that would wrap the 16-bit epoch.
`default_nettype none
module ir_constant_folder_top #(
  parameter int MAX_TEMPS = 256
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire        cfg_wdata_i,
  icf_in_if.sink     in_i,
  icf_out_if.source  out_o
);
  localparam int AW = (MAX_TEMPS > 1) ? $clog2(MAX_TEMPS) : 1;
  localparam int EW = 16;

  typedef enum logic [3:0] {
    S_IDLE, S_RDL, S_RDR, S_EXEC, S_DIV, S_MUL, S_OUT, S_CLR
  } state_e;

  state_e           state_q;
  logic             fold_en_q;
  icf_pkg::instr_t  ins_q;
  logic [EW-1:0]    epoch_q;
  logic [63:0]      l_q, r_q;
  logic             lk_q, rk_q;
  icf_pkg::result_t res_q;
  icf_pkg::result_t res_d;
  logic             res_v_q;
  logic [63:0]      quo_q, rem_q;
  logic [6:0]       cnt_q;
  logic [AW-1:0]    clr_q;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [63:0]    wdata, vdata;
  logic [EW:0]    tdata;
  logic [EW:0]    twdata;

  icf_ram #(.Width(64), .Depth(MAX_TEMPS)) u_val (
    .clk_i, .we_i(rec), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(vdata)
  );
  icf_ram #(.Width(EW + 1), .Depth(MAX_TEMPS)) u_tag (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(twdata),
    .raddr_i(raddr), .rdata_o(tdata)
  );

  // tag entry: {written, epoch}; known when written and epoch matches
  logic known_rd;
  assign known_rd = tdata[EW] && (tdata[EW-1:0] == epoch_q);

  function automatic logic in_range(input logic [63:0] t);
    in_range = (t < 64'(MAX_TEMPS));
  endfunction

  logic is_bin;
  assign is_bin = (ins_q.mode == icf_pkg::OP_ADD) || (ins_q.mode == icf_pkg::OP_SUB) ||
                  (ins_q.mode == icf_pkg::OP_MUL) || (ins_q.mode == icf_pkg::OP_DIV);

  logic is_addsub;
  assign is_addsub = (ins_q.mode == icf_pkg::OP_ADD) || (ins_q.mode == icf_pkg::OP_SUB);

  logic exec_go;
  assign exec_go = (state_q == S_EXEC) && !res_v_q;

  logic do_mul, do_div;
  assign do_mul = fold_en_q && lk_q && rk_q && (ins_q.mode == icf_pkg::OP_MUL);
  assign do_div = fold_en_q && lk_q && rk_q && (ins_q.mode == icf_pkg::OP_DIV) &&
                  (r_q != 64'd0);

  logic iter_done;
  assign iter_done = (state_q == S_DIV || state_q == S_MUL) && cnt_q == 7'd0;

  // function start that would wrap the epoch: clear the tags first
  logic wrap_clr;
  assign wrap_clr = in_i.valid && in_i.data.function_start && (epoch_q == '1);

  always_comb begin
    raddr = ins_q.left_operand[AW-1:0];
    if (state_q == S_IDLE) raddr = in_i.data.left_operand[AW-1:0];
    if (state_q == S_RDL) raddr = ins_q.right_operand[AW-1:0];
    if (state_q == S_RDR || state_q == S_EXEC) raddr = ins_q.dest_temp[AW-1:0];
  end

  logic [64:0] rem_sh;
  assign rem_sh = {rem_q, quo_q[63]};

  logic        rec;
  logic [63:0] rec_v;
  assign waddr  = (state_q == S_CLR) ? clr_q : ins_q.dest_temp[AW-1:0];
  assign wdata  = rec_v;
  assign twdata = (state_q == S_CLR) ? '0 : {1'b1, epoch_q};
  assign we     = rec || (state_q == S_CLR);

  always_comb begin
    rec = 1'b0;
    unique case (ins_q.mode)
      icf_pkg::OP_ADD: rec_v = l_q + r_q;
      icf_pkg::OP_SUB: rec_v = l_q - r_q;
      default:         rec_v = l_q;
    endcase
    if (exec_go && fold_en_q && in_range(ins_q.dest_temp) && !known_rd) begin
      if (ins_q.mode == icf_pkg::OP_ASSIGN && ins_q.left_is_const) rec = 1'b1;
      if (is_addsub && lk_q && rk_q) rec = 1'b1;
    end
    if (iter_done && in_range(ins_q.dest_temp) && lk_q) begin
      rec = 1'b1;
      rec_v = quo_q;
    end
  end

  assign in_i.ready = (state_q == S_IDLE) && !wrap_clr;
  assign out_o.valid = res_v_q;
  assign out_o.data  = res_q;

  function automatic icf_pkg::result_t pass(input icf_pkg::instr_t i);
    pass = '{i.mode, i.left_is_const, i.left_operand, i.right_is_const,
             i.right_operand, i.dest_temp};
  endfunction

  always_comb begin
    res_d = res_q;
    if (exec_go) begin
      res_d = pass(ins_q);
      if (fold_en_q) begin
        if ((ins_q.mode == icf_pkg::OP_ASSIGN || ins_q.mode == icf_pkg::OP_RETURN)
            && !ins_q.left_is_const && lk_q) begin
          res_d.out_left_is_const = 1'b1;
          res_d.out_left_operand  = l_q;
        end
        if (is_addsub && lk_q && rk_q) begin
          res_d.out_mode          = icf_pkg::OP_ASSIGN;
          res_d.out_left_is_const = 1'b1;
          res_d.out_left_operand  = rec_v;
        end
      end
    end
    if (iter_done) begin
      res_d.out_mode          = icf_pkg::OP_ASSIGN;
      res_d.out_left_is_const = 1'b1;
      res_d.out_left_operand  = quo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      fold_en_q <= 1'b0;
      epoch_q   <= '0;
      res_v_q   <= 1'b0;
      lk_q      <= 1'b0;
      rk_q      <= 1'b0;
      cnt_q     <= '0;
      clr_q     <= '0;
    end else begin
      if (cfg_we_i) fold_en_q <= cfg_wdata_i;
      if (res_v_q && out_o.ready) res_v_q <= 1'b0;
      res_q <= res_d;
      unique case (state_q)
        S_CLR: begin
          if (clr_q == AW'(MAX_TEMPS - 1)) begin
            clr_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_i.valid && in_i.ready) begin
            ins_q <= in_i.data;
            if (in_i.data.function_start) epoch_q <= epoch_q + 1'b1;
            state_q <= S_RDL;
          end else if (wrap_clr) begin
            epoch_q <= '0;
            state_q <= S_CLR;
          end
        end
        S_RDL: begin
          l_q  <= ins_q.left_is_const ? ins_q.left_operand : vdata;
          lk_q <= ins_q.left_is_const ||
                  (in_range(ins_q.left_operand) && known_rd);
          state_q <= S_RDR;
        end
        S_RDR: begin
          r_q  <= ins_q.right_is_const ? ins_q.right_operand : vdata;
          rk_q <= ins_q.right_is_const ||
                  (in_range(ins_q.right_operand) && known_rd);
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (!res_v_q) begin
            if (do_mul) begin
              quo_q   <= '0;
              rem_q   <= r_q;
              cnt_q   <= 7'd4;
              lk_q    <= !known_rd;
              state_q <= S_MUL;
            end else if (do_div) begin
              quo_q   <= l_q;
              rem_q   <= '0;
              cnt_q   <= 7'd64;
              lk_q    <= !known_rd;
              state_q <= S_DIV;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_MUL: begin
          if (cnt_q != 7'd0) begin
            cnt_q <= cnt_q - 7'd1;
            quo_q <= quo_q + l_q * {48'd0, rem_q[15:0]};
            l_q   <= {l_q[47:0], 16'd0};
            rem_q <= {16'd0, rem_q[63:16]};
          end else begin
            state_q <= S_OUT;
          end
        end
        S_DIV: begin
          if (cnt_q != 7'd0) begin
            cnt_q <= cnt_q - 7'd1;
            if (rem_sh >= {1'b0, r_q}) begin
              rem_q <= 64'(rem_sh - {1'b0, r_q});
              quo_q <= {quo_q[62:0], 1'b1};
            end else begin
              rem_q <= rem_sh[63:0];
              quo_q <= {quo_q[62:0], 1'b0};
            end
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_v_q) begin
            res_v_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/icf_ram.sv
`default_nettype none
module icf_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire
